/* rtl/htw_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the Huffman tree-walk decoder.
// No dependencies; imported by htw_node_ram and huffman_tree_walk_decoder.

package htw_pkg;

  localparam int unsigned IDX_W     = 9;
  localparam int unsigned SYM_W     = 8;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned IN_DATA_W = 48;
  localparam int unsigned OUT_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = CFG_IDX_W'(1);

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_DECODE = 1'b1
  } op_e;

  // One node table entry; left child sits in the lowest bits.
  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             leaf;
    logic [IDX_W-1:0] right;
    logic [IDX_W-1:0] left;
  } node_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
  } rd_req_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    node_t            data;
  } wr_req_t;

endpackage

/* rtl/huffman_tree_walk_decoder.sv */
`timescale 1ns / 1ps
// Huffman tree-walk decoder, top level. Depends on htw_pkg and htw_node_ram.
// A load transfer is accepted while idle. A decode transfer is accepted and then runs
// eight bit steps, each set by a dependent node table read, a test of the last node
// and a flush before the next input is accepted. A new symbol or the flush that waits
// on a full output register stalls the walk.
// Reset (rst_ni, asynchronous, active low) clears root, total and count; the root entry
// is then fetched from the table before input is accepted, as after a root write.

module huffman_tree_walk_decoder
  import htw_pkg::*;
#(
  parameter int unsigned TABLE_NODES = 512
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input stream.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata from bit 0: node_index[8:0], left_child[17:9], right_child[26:18],
  // leaf_flag[27], leaf_symbol[35:28], coded_byte[43:36], zeros[47:44].
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: op (0 loads a node, 1 decodes a byte).
  input  logic                  s_axis_tuser,
  // Output stream.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata from bit 0: symbol[7:0], done_res[8], zeros[15:9].
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast,
  // Configuration write channel.
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_W-1:0]      cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WALK  = 3'b010,
    ST_FLUSH = 3'b100
  } state_e;

  // Input field unpacking.
  logic [IDX_W-1:0]  in_node_index;
  logic [IDX_W-1:0]  in_left;
  logic [IDX_W-1:0]  in_right;
  logic              in_leaf;
  logic [SYM_W-1:0]  in_sym;
  logic [BYTE_W-1:0] in_byte;
  op_e               in_op;
  node_t             in_node;

  assign in_node_index = s_axis_tdata[8:0];
  assign in_left       = s_axis_tdata[17:9];
  assign in_right      = s_axis_tdata[26:18];
  assign in_leaf       = s_axis_tdata[27];
  assign in_sym        = s_axis_tdata[35:28];
  assign in_byte       = s_axis_tdata[43:36];
  assign in_op         = op_e'(s_axis_tuser);
  assign in_node       = '{symbol: in_sym, leaf: in_leaf, right: in_right, left: in_left};

  // Control state.
  state_e           state_q, state_d;
  logic [IDX_W-1:0] root_q, root_d;
  logic [CNT_W-1:0] total_q, total_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] cur_node_q, cur_node_d;
  logic             root_ok_q, root_ok_d;
  logic             refresh_q, refresh_d;
  logic             rd_pend_q, rd_pend_d;
  logic [3:0]       issue_cnt_q, issue_cnt_d;
  logic             pend_valid_q, pend_valid_d;
  logic             out_valid_q, out_valid_d;

  // Payload state.
  node_t             cur_entry_q, cur_entry_d;
  node_t             root_entry_q, root_entry_d;
  logic [BYTE_W-1:0] byte_q, byte_d;
  logic [SYM_W-1:0]  pend_sym_q, pend_sym_d;
  logic              pend_done_q, pend_done_d;
  logic [SYM_W-1:0]  out_sym_q, out_sym_d;
  logic              out_done_q, out_done_d;
  logic              out_last_q, out_last_d;

  rd_req_t rd_req;
  wr_req_t wr_req;
  node_t   rdata;

  htw_node_ram #(
    .TABLE_NODES(TABLE_NODES)
  ) u_node_ram (
    .clk_i  (clk_i),
    .rd_i   (rd_req),
    .wr_i   (wr_req),
    .rdata_o(rdata)
  );

  // Walk datapath. When a read is pending, rdata is the node just reached;
  // a leaf sends the walk back to the root, whose entry is kept in a register.
  logic             reached_leaf;
  logic             emit;
  logic             out_free;
  logic             stall;
  node_t            base_entry;
  logic [IDX_W-1:0] base_node;
  logic [IDX_W-1:0] child;
  logic [CNT_W-1:0] count_inc;

  assign reached_leaf = rd_pend_q && rdata.leaf;
  assign emit         = reached_leaf && (count_q < total_q);
  assign out_free     = !out_valid_q || m_axis_tready;
  // A new symbol pushes the held one into the output register, which must be free.
  assign stall        = emit && pend_valid_q && !out_free;
  assign count_inc    = count_q + CNT_W'(1);

  always_comb begin
    if (reached_leaf) begin
      base_entry = root_entry_q;
      base_node  = root_q;
    end else if (rd_pend_q) begin
      base_entry = rdata;
      base_node  = cur_node_q;
    end else begin
      base_entry = cur_entry_q;
      base_node  = cur_node_q;
    end
    child = byte_q[BYTE_W-1] ? base_entry.right : base_entry.left;
  end

  assign s_axis_tready = (state_q == ST_IDLE) && root_ok_q;
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    state_d      = state_q;
    root_d       = root_q;
    total_d      = total_q;
    count_d      = count_q;
    cur_node_d   = cur_node_q;
    root_ok_d    = root_ok_q;
    refresh_d    = 1'b0;
    rd_pend_d    = rd_pend_q;
    issue_cnt_d  = issue_cnt_q;
    pend_valid_d = pend_valid_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    cur_entry_d  = cur_entry_q;
    root_entry_d = root_entry_q;
    byte_d       = byte_q;
    pend_sym_d   = pend_sym_q;
    pend_done_d  = pend_done_q;
    out_sym_d    = out_sym_q;
    out_done_d   = out_done_q;
    out_last_d   = out_last_q;
    rd_req       = '0;
    wr_req       = '0;

    // A finished root fetch fills the root cache; the walk stands at the root then.
    if (refresh_q) begin
      root_entry_d = rdata;
      cur_entry_d  = rdata;
      root_ok_d    = 1'b1;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (!root_ok_q && !refresh_q) begin
          rd_req    = '{en: 1'b1, idx: root_q};
          refresh_d = 1'b1;
        end
        if (s_axis_tvalid && s_axis_tready) begin
          if (in_op == OP_LOAD) begin
            wr_req = '{en: 1'b1, idx: in_node_index, data: in_node};
            // Keep the cached entries coherent with the table. The memory
            // ignores indexes beyond its depth, and those never match a
            // node that the caches could hold with a nonzero entry.
            if ({1'b0, in_node_index} < (IDX_W + 1)'(TABLE_NODES)) begin
              if (in_node_index == root_q) begin
                root_entry_d = in_node;
              end
              if (in_node_index == cur_node_q) begin
                cur_entry_d = in_node;
              end
            end
          end else begin
            byte_d      = in_byte;
            issue_cnt_d = 4'(BYTE_W);
            rd_pend_d   = 1'b0;
            state_d     = ST_WALK;
          end
        end
      end

      ST_WALK: begin
        if (!stall) begin
          if (emit) begin
            count_d = count_inc;
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_sym_d   = pend_sym_q;
              out_done_d  = pend_done_q;
              out_last_d  = 1'b0;
            end
            pend_valid_d = 1'b1;
            pend_sym_d   = rdata.symbol;
            pend_done_d  = (count_inc == total_q);
          end
          if (issue_cnt_q != 4'd0) begin
            rd_req      = '{en: 1'b1, idx: child};
            cur_node_d  = child;
            rd_pend_d   = 1'b1;
            issue_cnt_d = issue_cnt_q - 4'd1;
            byte_d      = {byte_q[BYTE_W-2:0], 1'b0};
          end else begin
            cur_node_d  = base_node;
            cur_entry_d = base_entry;
            rd_pend_d   = 1'b0;
            state_d     = ST_FLUSH;
          end
        end
      end

      ST_FLUSH: begin
        // The held symbol is the last one of this byte.
        if (!pend_valid_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_sym_d    = pend_sym_q;
          out_done_d   = pend_done_q;
          out_last_d   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Configuration writes must arrive only while idle (the block does not enforce this) and take precedence.
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_ROOT: begin
          root_d     = cfg_data_i[IDX_W-1:0];
          cur_node_d = cfg_data_i[IDX_W-1:0];
          root_ok_d  = 1'b0;
          refresh_d  = 1'b0;
        end
        CFG_TOTAL: begin
          total_d = cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      root_q       <= '0;
      total_q      <= '0;
      count_q      <= '0;
      cur_node_q   <= '0;
      root_ok_q    <= 1'b0;
      refresh_q    <= 1'b0;
      rd_pend_q    <= 1'b0;
      issue_cnt_q  <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      root_q       <= root_d;
      total_q      <= total_d;
      count_q      <= count_d;
      cur_node_q   <= cur_node_d;
      root_ok_q    <= root_ok_d;
      refresh_q    <= refresh_d;
      rd_pend_q    <= rd_pend_d;
      issue_cnt_q  <= issue_cnt_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_entry_q  <= cur_entry_d;
    root_entry_q <= root_entry_d;
    byte_q       <= byte_d;
    pend_sym_q   <= pend_sym_d;
    pend_done_q  <= pend_done_d;
    out_sym_q    <= out_sym_d;
    out_done_q   <= out_done_d;
    out_last_q   <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_DATA_W - SYM_W - 1)'(0), out_done_q, out_sym_q};
  assign m_axis_tlast  = out_last_q;

endmodule

/* rtl/htw_node_ram.sv */
`timescale 1ns / 1ps
// Node table memory: one write port, one registered read port.
// Depends on htw_pkg. Indexes at or beyond the table depth read as zero.

module htw_node_ram
  import htw_pkg::*;
#(
  parameter int unsigned TABLE_NODES = 512
) (
  input  logic    clk_i,
  input  rd_req_t rd_i,
  input  wr_req_t wr_i,
  output node_t   rdata_o
);

  localparam int unsigned ADDR_W = $clog2(TABLE_NODES);
  localparam logic [IDX_W:0] NODES_LIM = (IDX_W + 1)'(TABLE_NODES);

  node_t mem [TABLE_NODES];
  node_t rdata_q;
  logic  oob_q;

  logic wr_in_range;
  logic rd_in_range;

  assign wr_in_range = {1'b0, wr_i.idx} < NODES_LIM;
  assign rd_in_range = {1'b0, rd_i.idx} < NODES_LIM;

  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_in_range) begin
      mem[wr_i.idx[ADDR_W-1:0]] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rdata_q <= mem[rd_i.idx[ADDR_W-1:0]];
      oob_q   <= !rd_in_range;
    end
  end

  assign rdata_o = oob_q ? '0 : rdata_q;

endmodule
